FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RPD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RPD_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define RPD_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

FILE: rtl/rpd_pkg.sv
// ----------------------------------------------------------------------------
// RLE pixel decoder package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rpd_pkg;

  localparam int FRAME_PIXELS = 4096;
  localparam int CNT_W        = $clog2(FRAME_PIXELS + 1);
  localparam int POS_W        = 12;
  localparam int RGB_W        = 24;
  localparam int CODE_W       = 8;
  localparam int KIND_W       = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int PAD_RUN      = 64;
  localparam int RUN_W        = $clog2(PAD_RUN + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_CODE    = 2'd0,
    KIND_PAD     = 2'd1,
    KIND_RESTART = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAL0 = 3'd0,
    REG_PAL1 = 3'd1,
    REG_PAL2 = 3'd2,
    REG_PAL3 = 3'd3,
    REG_PAD  = 3'd4
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic load_pad;
    logic clear;
    logic step;
  } rpd_cmd_t;

  typedef struct packed {
    logic full;
    logic last_pix;
    logic out_free;
  } rpd_stat_t;

endpackage

FILE: rtl/rpd_ctrl.sv
// ----------------------------------------------------------------------------
// RLE pixel decoder controller
// Accepts input items, decides what each one does and paces the pixel run.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpd_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rpd_pkg::KIND_W-1:0]  in_kind,
  input  rpd_pkg::rpd_stat_t          stat,
  output rpd_pkg::rpd_cmd_t           cmd
);

  rpd_pkg::state_t state_r;
  rpd_pkg::state_t state_nxt;
  logic            accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rpd_pkg::ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = rpd_pkg::ST_RUN;
        end
      end
      rpd_pkg::ST_RUN: begin
        if (cmd.step && stat.last_pix) begin
          state_nxt = rpd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rpd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == rpd_pkg::ST_IDLE);
    accept       = in_valid && in_ready;
    cmd.load     = 1'b0;
    cmd.load_pad = 1'b0;
    cmd.clear    = 1'b0;
    cmd.step     = (state_r == rpd_pkg::ST_RUN) && stat.out_free;
    if (accept) begin
      unique case (in_kind)
        rpd_pkg::KIND_CODE: begin
          cmd.load = !stat.full;
        end
        rpd_pkg::KIND_PAD: begin
          cmd.load     = !stat.full;
          cmd.load_pad = 1'b1;
        end
        rpd_pkg::KIND_RESTART: begin
          cmd.clear = 1'b1;
        end
        default: begin
          cmd.load = 1'b0;
        end
      endcase
    end
  end

  `RPD_ASSERT(a_load_enters_run, clk, rst_n, cmd.load |=> state_r == rpd_pkg::ST_RUN, "load did not start a run")
  `RPD_ASSERT(a_last_ends_run, clk, rst_n, (cmd.step && stat.last_pix) |=> state_r == rpd_pkg::ST_IDLE, "run did not end on its last pixel")
  `RPD_ASSERT_NEVER(a_no_load_when_full, clk, rst_n, cmd.load && stat.full, "load issued on a full frame")

endmodule

FILE: rtl/rpd_datapath.sv
// ----------------------------------------------------------------------------
// RLE pixel decoder datapath
// Palette registers, pixel and run counters, and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpd_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpd_pkg::RGB_W-1:0]      cfg_data,
  input  logic [rpd_pkg::CODE_W-1:0]     in_code_byte,
  input  rpd_pkg::rpd_cmd_t              cmd,
  output rpd_pkg::rpd_stat_t             stat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rpd_pkg::RGB_W-1:0]      out_pixel_rgb,
  output logic [rpd_pkg::POS_W-1:0]      out_pixel_position,
  output logic                           out_is_padding,
  output logic                           out_frame_full,
  output logic                           out_last
);

  logic [rpd_pkg::RGB_W-1:0] pal_r [4];
  logic [rpd_pkg::RGB_W-1:0] pad_color_r;
  logic [rpd_pkg::CNT_W-1:0] count_r;
  logic [rpd_pkg::CNT_W-1:0] count_nxt;
  logic [rpd_pkg::RUN_W-1:0] left_r;
  logic [rpd_pkg::RUN_W-1:0] left_nxt;
  logic [rpd_pkg::RUN_W-1:0] run_len;
  logic [rpd_pkg::RGB_W-1:0] rgb_r;
  logic                      pad_r;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic                      at_end;

  always_comb begin
    if (cmd.load_pad) begin
      run_len = rpd_pkg::RUN_W'(rpd_pkg::PAD_RUN);
    end else begin
      run_len = rpd_pkg::RUN_W'(in_code_byte[rpd_pkg::CODE_W-1:2]) + rpd_pkg::RUN_W'(1);
    end
    at_end         = (count_r == rpd_pkg::CNT_W'(rpd_pkg::FRAME_PIXELS - 1));
    stat.full      = (count_r == rpd_pkg::CNT_W'(rpd_pkg::FRAME_PIXELS));
    stat.last_pix  = (left_r == rpd_pkg::RUN_W'(1)) || at_end;
    stat.out_free  = !out_valid_r || out_ready;

    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.step) begin
      count_nxt = count_r + rpd_pkg::CNT_W'(1);
    end

    left_nxt = left_r;
    if (cmd.load) begin
      left_nxt = run_len;
    end else if (cmd.step) begin
      left_nxt = left_r - rpd_pkg::RUN_W'(1);
    end

    out_valid_nxt = out_valid_r;
    if (cmd.step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_r[0]    <= rpd_pkg::RGB_W'(24'hFFFFFF);
      pal_r[1]    <= rpd_pkg::RGB_W'(24'h0000FF);
      pal_r[2]    <= rpd_pkg::RGB_W'(24'h00FF00);
      pal_r[3]    <= rpd_pkg::RGB_W'(24'h000000);
      pad_color_r <= '0;
      count_r     <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rpd_pkg::REG_PAL0: pal_r[0]    <= cfg_data;
          rpd_pkg::REG_PAL1: pal_r[1]    <= cfg_data;
          rpd_pkg::REG_PAL2: pal_r[2]    <= cfg_data;
          rpd_pkg::REG_PAL3: pal_r[3]    <= cfg_data;
          rpd_pkg::REG_PAD:  pad_color_r <= cfg_data;
          default: pad_color_r <= pad_color_r;
        endcase
      end
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pad_r <= cmd.load_pad;
      if (cmd.load_pad) begin
        rgb_r <= pad_color_r;
      end else begin
        rgb_r <= pal_r[in_code_byte[1:0]];
      end
    end
    if (cmd.step) begin
      out_pixel_rgb      <= rgb_r;
      out_pixel_position <= count_r[rpd_pkg::POS_W-1:0];
      out_is_padding     <= pad_r;
      out_frame_full     <= at_end;
      out_last           <= stat.last_pix;
    end
  end

  assign out_valid = out_valid_r;

  `RPD_ASSERT_NEVER(a_count_in_frame, clk, rst_n, count_r > rpd_pkg::CNT_W'(rpd_pkg::FRAME_PIXELS), "pixel count past frame end")
  `RPD_ASSERT_NEVER(a_step_needs_room, clk, rst_n, cmd.step && !stat.out_free, "pixel produced over an untaken one")
  `RPD_ASSERT(a_full_is_last, clk, rst_n, (out_valid_r && out_frame_full) |-> out_last, "frame-completing pixel not marked last")

endmodule

FILE: rtl/rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// RLE pixel decoder
// Expands run-length coded items into palette-colored pixels of one frame.
// ----------------------------------------------------------------------------
// Input items arrive on the in_ valid/ready channel: a code byte expands to
// (bits 7..2) + 1 pixels of palette color (bits 1..0), a pad step to up to 64
// pixels of the pad color, and a restart clears the pixel count. Each pixel
// leaves on the out_ valid/ready channel as one transfer.
// Runs are cut where the frame fills; once full, code bytes and pad steps
// produce nothing until a restart.
// The palette and pad color are written through cfg_we/cfg_index/cfg_data
// by the user only while the block is idle; the block does not enforce it.
// Indexes beyond four are ignored. An accepted item loads the single run
// counter, which then keeps the block busy and emits one pixel per cycle
// into the output register while it is free; when the receiver stalls, the
// run pauses and the output holds; items with no pixels keep in_ready high.
// The next item is accepted as soon as the last pixel sits in the output
// register. Reset clears the pixel count and loads the default palette.
// ----------------------------------------------------------------------------
module rle_pixel_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpd_pkg::RGB_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rpd_pkg::KIND_W-1:0]     in_kind,
  input  logic [rpd_pkg::CODE_W-1:0]     in_code_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rpd_pkg::RGB_W-1:0]      out_pixel_rgb,
  output logic [rpd_pkg::POS_W-1:0]      out_pixel_position,
  output logic                           out_is_padding,
  output logic                           out_frame_full,
  output logic                           out_last
);

  rpd_pkg::rpd_cmd_t  cmd;
  rpd_pkg::rpd_stat_t stat;

  rpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .stat     (stat),
    .cmd      (cmd)
  );

  rpd_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_code_byte       (in_code_byte),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pixel_rgb      (out_pixel_rgb),
    .out_pixel_position (out_pixel_position),
    .out_is_padding     (out_is_padding),
    .out_frame_full     (out_frame_full),
    .out_last           (out_last)
  );

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// RLE pixel decoder testbench
// Drives code bytes, pad steps, restarts and unused kinds into the decoder,
// expands each accepted item into the pixels it should produce and checks
// every pixel transfer field by field. Both channels idle at random, and the
// palette is reprogrammed between phases, including all-ones and all-zeros.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rpd_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 10;
  localparam int IDLE_PCT      = 38;
  localparam int SETTLE_CYCLES = 6;
  localparam int NUM_PHASES    = 4;
  localparam int BURST_ITEMS   = 40;
  localparam int NUM_IDX_SLOTS = 1 << CFG_IDX_W;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] code;
  } rle_item_t;

  typedef struct packed {
    logic [RGB_W-1:0] rgb;
    logic [POS_W-1:0] pos;
    logic             pad;
    logic             full;
    logic             last;
  } pixel_t;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [RGB_W-1:0]     cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic [KIND_W-1:0]    in_kind      = '0;
  logic [CODE_W-1:0]    in_code_byte = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [RGB_W-1:0]     out_pixel_rgb;
  logic [POS_W-1:0]     out_pixel_position;
  logic                 out_is_padding;
  logic                 out_frame_full;
  logic                 out_last;

  rle_item_t        pending_items[$];
  rle_item_t        cur_item;
  pixel_t           expected_pixels[$];
  logic [RGB_W-1:0] palette_rgb[4];
  logic [RGB_W-1:0] pad_rgb;
  logic [CNT_W-1:0] frame_fill;
  int               items_issued = 0;
  int               items_taken  = 0;
  int               error_count  = 0;
  logic             steady       = 1'b0;

  rle_pixel_decoder u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_code_byte      (in_code_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_rgb     (out_pixel_rgb),
    .out_pixel_position(out_pixel_position),
    .out_is_padding    (out_is_padding),
    .out_frame_full    (out_frame_full),
    .out_last          (out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void expand_item(input rle_item_t it);
    logic [RGB_W-1:0] rgb;
    logic             pad;
    int unsigned      run_len;
    int unsigned      room;
    int unsigned      n;
    pixel_t           px;
    case (it.kind)
      KIND_CODE: begin
        rgb     = palette_rgb[it.code[1:0]];
        run_len = int'(it.code[CODE_W-1:2]) + 1;
        pad     = 1'b0;
      end
      KIND_PAD: begin
        rgb     = pad_rgb;
        run_len = PAD_RUN;
        pad     = 1'b1;
      end
      KIND_RESTART: begin
        frame_fill = '0;
        return;
      end
      default: return;
    endcase
    if (frame_fill >= FRAME_PIXELS) return;
    room = FRAME_PIXELS - frame_fill;
    n    = (run_len < room) ? run_len : room;
    for (int unsigned k = 0; k < n; k++) begin
      px.rgb  = rgb;
      px.pos  = frame_fill[POS_W-1:0];
      px.pad  = pad;
      frame_fill = frame_fill + 1'b1;
      px.full = (frame_fill == FRAME_PIXELS);
      px.last = (k + 1 == n);
      expected_pixels = {expected_pixels, px};
    end
  endfunction

  // Input driver: presents the next pending item once the previous transfer
  // has completed, with random gaps.
  always @(posedge clk) begin
    logic present;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expand_item(cur_item);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        present = 1'b0;
        if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          cur_item     = pending_items.pop_front();
          present      = 1'b1;
          in_kind      <= cur_item.kind;
          in_code_byte <= cur_item.code;
        end
        in_valid <= present;
      end
    end
  end

  // Pixel monitor: checks each output transfer against the oldest expectation.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel at position %0d", out_pixel_position);
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_rgb !== want.rgb) begin
            $error("pixel_rgb: expected %h, got %h", want.rgb, out_pixel_rgb);
            error_count++;
          end
          if (out_pixel_position !== want.pos) begin
            $error("pixel_position: expected %0d, got %0d", want.pos, out_pixel_position);
            error_count++;
          end
          if (out_is_padding !== want.pad) begin
            $error("is_padding: expected %b, got %b", want.pad, out_is_padding);
            error_count++;
          end
          if (out_frame_full !== want.full) begin
            $error("frame_full: expected %b, got %b", want.full, out_frame_full);
            error_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_last);
            error_count++;
          end
        end
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic push_item(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code);
    rle_item_t it;
    it.kind = kind;
    it.code = code;
    pending_items = {pending_items, it};
    items_issued++;
  endtask

  task automatic wait_drained();
    while (items_taken != items_issued || expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RGB_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx <= REG_PAL3) begin
      palette_rgb[idx[1:0]] = val;
    end else if (idx == REG_PAD) begin
      pad_rgb = val;
    end
  endtask

  task automatic program_colors(input logic [RGB_W-1:0] c0, input logic [RGB_W-1:0] c1,
                                input logic [RGB_W-1:0] c2, input logic [RGB_W-1:0] c3,
                                input logic [RGB_W-1:0] pad);
    write_reg(REG_PAL0, c0);
    write_reg(REG_PAL1, c1);
    write_reg(REG_PAL2, c2);
    write_reg(REG_PAL3, c3);
    write_reg(REG_PAD, pad);
    // Writes to the unused indexes must leave every color untouched.
    for (int i = REG_PAD + 1; i < NUM_IDX_SLOTS; i++) begin
      write_reg(CFG_IDX_W'(i), RGB_W'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  // Restart, then mostly long runs until the frame fills, then a code byte and
  // a pad step that must be dropped, and one item of random kind.
  task automatic fill_frame();
    int          tally;
    int unsigned roll;
    logic [5:0]  run_bits;
    push_item(KIND_RESTART, CODE_W'($urandom));
    tally = 0;
    while (tally < FRAME_PIXELS) begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        push_item(KIND_PAD, CODE_W'($urandom));
        tally += PAD_RUN;
      end else if (roll < 18) begin
        push_item(KIND_UNUSED, CODE_W'($urandom));
      end else begin
        run_bits = 6'($urandom_range(63, 24));
        push_item(KIND_CODE, {run_bits, 2'($urandom_range(3))});
        tally += int'(run_bits) + 1;
      end
    end
    push_item(KIND_CODE, CODE_W'($urandom));
    push_item(KIND_PAD, CODE_W'($urandom));
    push_item(KIND_W'($urandom_range(3)), CODE_W'($urandom));
  endtask

  task automatic mixed_burst(input int count);
    int unsigned roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 70)      push_item(KIND_CODE, CODE_W'($urandom));
      else if (roll < 82) push_item(KIND_PAD, CODE_W'($urandom));
      else if (roll < 92) push_item(KIND_RESTART, CODE_W'($urandom));
      else                push_item(KIND_UNUSED, CODE_W'($urandom));
    end
  endtask

  initial begin
    palette_rgb[0] = 24'hFFFFFF;
    palette_rgb[1] = 24'h0000FF;
    palette_rgb[2] = 24'h00FF00;
    palette_rgb[3] = 24'h000000;
    pad_rgb        = 24'h000000;
    frame_fill     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    push_item(KIND_CODE, 8'h00);
    push_item(KIND_CODE, 8'h01);
    push_item(KIND_CODE, 8'h02);
    push_item(KIND_CODE, 8'h03);
    push_item(KIND_CODE, 8'hFF);
    push_item(KIND_CODE, 8'hFC);
    push_item(KIND_PAD, 8'hAA);
    push_item(KIND_UNUSED, 8'h55);
    push_item(KIND_RESTART, 8'hFF);
    push_item(KIND_CODE, 8'h7E);
    push_item(KIND_PAD, 8'h00);
    push_item(KIND_UNUSED, 8'hFF);
    push_item(KIND_RESTART, 8'h00);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       program_colors('1, '1, '1, '1, '1);
        1:       program_colors('0, '0, '0, '0, '0);
        default: program_colors(RGB_W'($urandom), RGB_W'($urandom), RGB_W'($urandom),
                                RGB_W'($urandom), RGB_W'($urandom));
      endcase
      steady = (p == 1);
      fill_frame();
      mixed_burst(BURST_ITEMS);
      wait_drained();
      steady = 1'b0;
    end

    if (error_count == 0) begin
      $display("rle_pixel_decoder verification clean");
    end else begin
      $display("rle_pixel_decoder verification failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("rle_pixel_decoder verification failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rpd_pkg.sv
rtl/rpd_ctrl.sv
rtl/rpd_datapath.sv
rtl/rle_pixel_decoder.sv
tb/tb_top.sv
